[rtl/cdf97_pkg.sv]
// package: constants and helpers for the cdf 9/7 lifting wavelet block
package cdf97_pkg;

    localparam int DATA_W = 32;
    localparam int COEF_W = 32;
    localparam int Q_SHIFT = 30;

    localparam logic signed [COEF_W-1:0] C_P1   = -32'sd1703098781;
    localparam logic signed [COEF_W-1:0] C_U1   = -32'sd56886969;
    localparam logic signed [COEF_W-1:0] C_P2   = 32'sd948018549;
    localparam logic signed [COEF_W-1:0] C_U2   = 32'sd476211856;
    localparam logic signed [COEF_W-1:0] C_K    = 32'sd1234378323;
    localparam logic signed [COEF_W-1:0] C_INVK = 32'sd934009844;

    // one multiply-add operation of the datapath
    typedef struct packed {
        logic                     lift;
        logic signed [COEF_W-1:0] coef;
    } op_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (v > hi)
                sat32 = 32'sh7fffffff;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

[rtl/cdf97_mac.sv]
// multiply, round, saturate: out = sat(rnd(c*s) + (lift?acc:0))
module cdf97_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 lift,
    input  logic signed [cdf97_pkg::DATA_W:0]    sum,
    input  logic signed [cdf97_pkg::DATA_W-1:0]  acc,
    input  logic signed [cdf97_pkg::COEF_W-1:0]  coef,
    output logic                                 out_valid,
    output logic signed [cdf97_pkg::DATA_W-1:0]  result
);
    import cdf97_pkg::*;

    logic signed [64:0]       prod_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic                     lift_reg;
    logic                     valid_reg;
    logic signed [65:0]       rounded;
    logic signed [65:0]       total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 65'(sum * coef);
        acc_reg  <= acc;
        lift_reg <= lift;
    end

    always_comb
    begin
        rounded = (66'(prod_reg) + (66'sd1 <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
        total   = lift_reg ? rounded + 66'(acc_reg) : rounded;
    end

    assign out_valid = valid_reg;
    assign result    = sat32(total);

endmodule

[rtl/cdf97_lifting_wavelet.sv]
// top level of the one-level cdf 9/7 lifting wavelet block
// usage: with busy low, raise start for one cycle per sample on sample_in; the
// transaction carrying last_in = 1 closes the sequence and starts a run. the
// run direction comes from the direction register, written with direction_we
// while the block is idle. during a run busy is high and no sample is taken.
// results leave on coeff_out with strobe high for one cycle each, last_out on
// the final one; an odd length gives one result with odd_length_error set.
// schedule: a lifting pass makes three reads per updated element and a scale
// pass one, each pass followed by a drain while the multiply and round path
// writes back; four lift passes and one scale pass run, then the read-out,
// and the final result is on the outputs in the first cycle with busy low.
// an odd length keeps busy high only while in the error state. the memory
// has one read and one write port, and the three reads per lifted element
// set the rate. the halves are split by address mapping on read-out
// (forward) or on every access after the load (inverse).
// reset clears the fill count, direction and state; memory contents are left.
// the receiver cannot stall: results are presented once and never held.
module cdf97_lifting_wavelet #(
    parameter int MAX_LEN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cdf97_pkg::DATA_W-1:0] sample_in,
    input  logic                                last_in,
    input  logic                                direction_we,
    input  logic                                direction_wdata,
    output logic                                strobe,
    output logic signed [cdf97_pkg::DATA_W-1:0] coeff_out,
    output logic                                last_out,
    output logic                                odd_length_error
);
    import cdf97_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {S_LOAD, S_PASS, S_DRAIN, S_OUT, S_ERR} state_t;

    logic signed [DATA_W-1:0] mem [MAX_LEN];

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic                dir_reg;
    logic                run_dir_reg;
    logic [2:0]          pass_reg;
    logic [CW-1:0]       idx_reg;
    logic                rd_valid_reg;
    logic                rd_last_reg;
    logic signed [DATA_W-1:0] left_reg;
    logic signed [DATA_W-1:0] centre_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [1:0]          phase_reg;

    // scratch for the pass sequencing
    logic [CW-1:0]       n_half;
    op_t                 op;
    logic                parity;
    logic                is_scale;

    logic                mac_valid;
    logic signed [DATA_W-1:0] mac_result;
    logic [AW-1:0]       wb_addr_reg;

    logic [AW-1:0]       rd_addr;
    logic                rd_en;
    logic                accept;

    assign busy   = (state_reg != S_LOAD);
    assign accept = start && !busy;
    assign n_half = count_reg >> 1;

    // pass schedule: forward p1 u1 p2 u2 scale, inverse scale u2 p2 u1 p1
    always_comb
    begin
        op       = '0;
        parity   = 1'b0;
        is_scale = 1'b0;
        case (pass_reg)
            3'd0:
            begin
                is_scale = run_dir_reg;
                parity   = 1'b1;
                op.coef  = run_dir_reg ? C_INVK : C_P1;
            end
            3'd1:
            begin
                parity  = 1'b0;
                op.coef = run_dir_reg ? -C_U2 : C_U1;
            end
            3'd2:
            begin
                parity  = 1'b1;
                op.coef = run_dir_reg ? -C_P2 : C_P2;
            end
            3'd3:
            begin
                parity  = 1'b0;
                op.coef = run_dir_reg ? -C_U1 : C_U2;
            end
            3'd4:
            begin
                is_scale = !run_dir_reg;
                parity   = 1'b1;
                op.coef  = run_dir_reg ? -C_P1 : C_K;
            end
            default:
            begin
                op.coef = '0;
            end
        endcase
        op.lift = !is_scale;
    end

    // each element takes three reads: left, right, centre (scale: one)
    logic [CW-1:0] elem;
    logic [CW-1:0] lft;
    logic [CW-1:0] rgt;
    logic signed [COEF_W-1:0] scale_c;
    always_comb
    begin
        elem = is_scale ? idx_reg : ((idx_reg << 1) | CW'(parity));
        lft  = (elem == '0) ? CW'(1) : elem - CW'(1);
        rgt  = (elem + CW'(1) < count_reg) ? elem + CW'(1) : elem - CW'(1);
        rd_en   = 1'b0;
        rd_addr = '0;
        if (state_reg == S_PASS)
        begin
            rd_en = 1'b1;
            if (is_scale)
                rd_addr = elem[AW-1:0];
            else
            begin
                case (phase_reg)
                    2'd0:    rd_addr = lft[AW-1:0];
                    2'd1:    rd_addr = rgt[AW-1:0];
                    default: rd_addr = elem[AW-1:0];
                endcase
            end
        end
        else if (state_reg == S_OUT)
        begin
            rd_en = 1'b1;
            if (!run_dir_reg && idx_reg < n_half)
                rd_addr = AW'(idx_reg << 1);
            else if (!run_dir_reg)
                rd_addr = AW'(((idx_reg - n_half) << 1) | CW'(1));
            else
                rd_addr = idx_reg[AW-1:0];
        end
        // scale: forward even k / odd 1/k, inverse odd k / even 1/k
        if (run_dir_reg)
            scale_c = elem[0] ? C_K : C_INVK;
        else
            scale_c = elem[0] ? C_INVK : C_K;
    end

    // the load address for inverse depends on the final length, so inverse
    // data are stored linearly and remapped on read and write-back instead
    logic [AW-1:0] map_addr;
    always_comb
    begin
        map_addr = rd_addr;
    end

    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0] perm_addr;
    logic [CW-1:0] pe;
    always_comb
    begin
        // inverse: natural position p maps to stored position
        pe = CW'(map_addr);
        if (run_dir_reg)
            perm_addr = pe[0] ? AW'(n_half + (pe >> 1)) : AW'(pe >> 1);
        else
            perm_addr = map_addr;
    end

    // memory writes: load, then pass write back (inverse uses the permutation)
    logic [CW-1:0] wpe;
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = sample_in;
        wpe       = CW'(wb_addr_reg);
        if (accept && count_reg < CW'(MAX_LEN))
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[AW-1:0];
        end
        else if (mac_valid)
        begin
            mem_we    = 1'b1;
            mem_wdata = mac_result;
            if (run_dir_reg)
                mem_waddr = wpe[0] ? AW'(n_half + (wpe >> 1)) : AW'(wpe >> 1);
            else
                mem_waddr = wb_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[run_dir_reg ? perm_addr : rd_addr];
    end

    // operand gathering
    logic issue_reg;
    logic signed [DATA_W:0] sum_v;
    logic signed [DATA_W-1:0] acc_v;
    logic signed [COEF_W-1:0] coef_reg;
    logic scale_reg;
    logic [AW-1:0] el_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            scale_reg <= 1'b0;
        end
        else
        begin
            issue_reg <= (state_reg == S_PASS) && (is_scale || phase_reg == 2'd2);
            scale_reg <= !op.lift;
        end
    end

    always_ff @(posedge clk)
    begin
        el_d_reg <= elem[AW-1:0];
        coef_reg <= is_scale ? scale_c : op.coef;
        if (state_reg == S_PASS && !is_scale && phase_reg == 2'd1)
            left_reg <= rd_data_reg;
        if (state_reg == S_PASS && !is_scale && phase_reg == 2'd2)
            centre_reg <= rd_data_reg;
        wb_addr_reg <= el_d_reg;
    end

    always_comb
    begin
        sum_v = scale_reg ? 33'(rd_data_reg) : 33'(left_reg) + 33'(centre_reg);
        acc_v = rd_data_reg;
    end

    // in the lift case the data read last is the centre, the sum is left+right
    logic signed [DATA_W:0] lift_sum;
    assign lift_sum = 33'(left_reg) + 33'(centre_reg);

    cdf97_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue_reg),
        .lift      (!scale_reg),
        .sum       (scale_reg ? sum_v : lift_sum),
        .acc       (acc_v),
        .coef      (coef_reg),
        .out_valid (mac_valid),
        .result    (mac_result)
    );

    // phase 0 reads left, phase 1 reads right (left lands), phase 2 reads
    // centre (right lands in centre_reg), centre arrives with issue
    logic [CW-1:0] pass_len;
    assign pass_len = is_scale ? count_reg : n_half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            dir_reg       <= 1'b0;
            run_dir_reg   <= 1'b0;
            pass_reg      <= '0;
            idx_reg       <= '0;
            phase_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            strobe        <= 1'b0;
            last_out      <= 1'b0;
            odd_length_error <= 1'b0;
            coeff_out     <= '0;
        end
        else
        begin
            strobe           <= 1'b0;
            last_out         <= 1'b0;
            odd_length_error <= 1'b0;
            if (direction_we)
                dir_reg <= direction_wdata;
            rd_valid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg < CW'(MAX_LEN))
                            count_reg <= count_reg + CW'(1);
                        if (last_in)
                        begin
                            run_dir_reg <= dir_reg;
                            pass_reg    <= '0;
                            idx_reg     <= '0;
                            phase_reg   <= '0;
                            if (count_reg < CW'(MAX_LEN))
                            begin
                                if (!count_reg[0])
                                    state_reg <= S_ERR;
                                else
                                    state_reg <= S_PASS;
                            end
                            else
                                state_reg <= count_reg[0] ? S_ERR : S_PASS;
                        end
                    end
                end
                S_ERR:
                begin
                    strobe           <= 1'b1;
                    last_out         <= 1'b1;
                    odd_length_error <= 1'b1;
                    coeff_out        <= '0;
                    count_reg        <= '0;
                    state_reg        <= S_LOAD;
                end
                S_PASS:
                begin
                    if (!is_scale && phase_reg != 2'd2)
                        phase_reg <= phase_reg + 2'd1;
                    else
                    begin
                        phase_reg <= '0;
                        if (idx_reg + CW'(1) == pass_len)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_DRAIN;
                        end
                        else
                            idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (phase_reg == 2'd3)
                    begin
                        phase_reg <= '0;
                        if (pass_reg == 3'd4)
                        begin
                            state_reg <= S_OUT;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            pass_reg  <= pass_reg + 3'd1;
                            state_reg <= S_PASS;
                        end
                    end
                    else
                        phase_reg <= phase_reg + 2'd1;
                end
                S_OUT:
                begin
                    if (idx_reg == count_reg)
                    begin
                        count_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b1;
                        rd_last_reg  <= (idx_reg + CW'(1) == count_reg);
                        idx_reg      <= idx_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
            if (rd_valid_reg)
            begin
                strobe    <= 1'b1;
                coeff_out <= rd_data_reg;
                last_out  <= rd_last_reg;
            end
        end
    end

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> busy)
        else $error("busy low outside load");
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        odd_length_error |-> (strobe && last_out))
        else $error("error result malformed");
    a_no_wb_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !mac_valid)
        else $error("write back while loading");
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |-> strobe)
        else $error("last without strobe");

endmodule
